// ===== rtl/core/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants for the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 3;
   localparam int PIX_W     = 32;

   localparam int IMAGE_PIXELS_DEF = 16384;
   localparam int DIM_MAX_DEF      = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA  = 3'd4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last;
   } rsp_type;

endpackage

// ===== rtl/core/nns_store.sv =====
// ----------------------------------------------------------------------------
// nns_store
// Single-port-write, registered-read image store.
// ----------------------------------------------------------------------------
module nns_store
   import nns_pkg::*;
#(
   parameter int DEPTH = IMAGE_PIXELS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nns_div.sv =====
// ----------------------------------------------------------------------------
// nns_div
// Restoring divider, one quotient bit per cycle, shared by row and column.
// ----------------------------------------------------------------------------
module nns_div
   import nns_pkg::*;
#(
   parameter int N_W = 25,
   parameter int D_W = 13
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   dq_ff, dq_in;
   logic [D_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W:0]     shifted;
   logic [D_W:0]     diff;
   logic             ge;

   assign shifted = {rem_ff, dq_ff[N_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         dq_in  = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(N_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
         dq_in  = {dq_ff[N_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = dq_ff;

endmodule

// ===== rtl/core/nearest_neighbor_image_scaler_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Nearest-neighbour image scaler with an iterative shared divider.
//
// Usage: write the geometry over the csr_ port (one register per beat, no
// wait). Offer source pixels in raster order with start high, op = load;
// then each start with op = fetch returns the next destination pixel in
// raster order on rsp_item, marked by a one-cycle rsp_valid strobe.
// An item is taken at an edge where start is high and busy is low.
// A load holds busy high for one cycle, so loads cannot be taken back to back.
// A fetch holds busy high while it steps through the multiply, divide,
// index, read and output states, using the bit-serial divider once for
// the row and once for the column; no new item is taken until it is
// done, and rsp_valid rises in the cycle busy falls.
// A fetch before the whole source is loaded is dropped without raising
// busy; a load once it is complete holds busy for one cycle and is dropped.
// Reset clears the load and walk positions and sets every dimension to 1
// with alpha on; the store contents are undefined until loaded. The
// receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_top
   import nns_pkg::*;
#(
   parameter int IMAGE_PIXELS = IMAGE_PIXELS_DEF,
   parameter int DIM_MAX      = DIM_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item
);

   localparam int DIM_W = $clog2(DIM_MAX + 1);
   localparam int RC_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int P_W   = RC_W + DIM_W;
   localparam int AW    = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;
   localparam int LA_W  = $clog2(IMAGE_PIXELS + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_MUL_R = 4'd2;
   localparam logic [3:0] ST_DST_R = 4'd3;
   localparam logic [3:0] ST_DWT_R = 4'd4;
   localparam logic [3:0] ST_MUL_C = 4'd5;
   localparam logic [3:0] ST_DST_C = 4'd6;
   localparam logic [3:0] ST_DWT_C = 4'd7;
   localparam logic [3:0] ST_IDX   = 4'd8;
   localparam logic [3:0] ST_RD    = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      logic [31:0] w;
      begin
         w = 32'(v);
         if (w == 32'd0) begin
            return DIM_W'(1);
         end
         if (w > 32'(DIM_MAX)) begin
            return DIM_W'(DIM_MAX);
         end
         return DIM_W'(w);
      end
   endfunction

   logic [3:0]       state_ff, state_in;
   logic [CSR_W-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [CSR_W-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic             alpha_ff, alpha_in;
   logic [LA_W-1:0]  load_addr_ff, load_addr_in;
   logic [RC_W-1:0]  load_col_ff, load_col_in, load_row_ff, load_row_in;
   logic             full_ff, full_in;
   logic [RC_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic [RC_W-1:0]  sr_ff, sr_in, sc_ff, sc_in;
   logic [P_W:0]     idx_ff, idx_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [RC_W-1:0]  mul_a;
   logic [DIM_W-1:0] mul_b;
   logic [P_W-1:0]   mul_p;
   logic             div_start, div_busy;
   logic [P_W-1:0]   div_dividend, div_q;
   logic [DIM_W-1:0] div_divisor;
   logic             wr_en, rd_en, oob;
   logic [PIX_W-1:0] rd_data, pix_sel;
   logic             col_end, row_end, ld_col_end, ld_row_end;

   assign sw = clamp_dim(src_w_ff);
   assign sh = clamp_dim(src_h_ff);
   assign dw = clamp_dim(dst_w_ff);
   assign dh = clamp_dim(dst_h_ff);

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_R: begin
            mul_a = row_ff;
            mul_b = sh;
         end
         ST_MUL_C: begin
            mul_a = col_ff;
            mul_b = sw;
         end
         default: begin
            mul_a = sr_ff;
            mul_b = sw;
         end
      endcase
   end

   assign mul_p = {{DIM_W{1'b0}}, mul_a} * {{RC_W{1'b0}}, mul_b};

   assign div_start    = (state_ff == ST_DST_R) || (state_ff == ST_DST_C);
   assign div_dividend = prod_ff;
   assign div_divisor  = (state_ff == ST_DST_R) ? dh : dw;

   nns_div #(
      .N_W (P_W),
      .D_W (DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign wr_en = (state_ff == ST_LOAD) && !full_ff
                  && (load_addr_ff < LA_W'(IMAGE_PIXELS));
   assign rd_en = state_ff == ST_RD;

   nns_store #(
      .DEPTH (IMAGE_PIXELS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(load_addr_ff)),
      .wr_data (pix_ff),
      .rd_en   (rd_en),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   assign oob        = 64'(idx_ff) >= 64'(IMAGE_PIXELS);
   assign col_end    = DIM_W'(col_ff) == (dw - DIM_W'(1));
   assign row_end    = DIM_W'(row_ff) == (dh - DIM_W'(1));
   assign ld_col_end = DIM_W'(load_col_ff) == (sw - DIM_W'(1));
   assign ld_row_end = DIM_W'(load_row_ff) == (sh - DIM_W'(1));

   always_comb begin
      pix_sel = oob ? '0 : rd_data;
      if (!alpha_ff) begin
         pix_sel[PIX_W-1:PIX_W-8] = 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      src_w_in     = src_w_ff;
      src_h_in     = src_h_ff;
      dst_w_in     = dst_w_ff;
      dst_h_in     = dst_h_ff;
      alpha_in     = alpha_ff;
      load_addr_in = load_addr_ff;
      load_col_in  = load_col_ff;
      load_row_in  = load_row_ff;
      full_in      = full_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pix_in       = pix_ff;
      prod_in      = prod_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.op == OP_LOAD) begin
                  pix_in   = req_item.pixel_in;
                  state_in = ST_LOAD;
               end else if (full_ff) begin
                  if ((DIM_W'(row_ff) >= dh) || (DIM_W'(col_ff) >= dw)) begin
                     row_in = '0;
                     col_in = '0;
                  end
                  state_in = ST_MUL_R;
               end
            end
         end
         ST_LOAD: begin
            if (!full_ff) begin
               load_addr_in = load_addr_ff + 1'b1;
               if (ld_col_end) begin
                  load_col_in = '0;
                  load_row_in = load_row_ff + 1'b1;
               end else begin
                  load_col_in = load_col_ff + 1'b1;
               end
               if ((ld_col_end && ld_row_end)
                   || (load_addr_ff + 1'b1 >= LA_W'(IMAGE_PIXELS))) begin
                  full_in = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         ST_MUL_R: begin
            prod_in  = mul_p;
            state_in = ST_DST_R;
         end
         ST_DST_R: begin
            state_in = ST_DWT_R;
         end
         ST_DWT_R: begin
            if (!div_busy) begin
               sr_in    = div_q[RC_W-1:0];
               state_in = ST_MUL_C;
            end
         end
         ST_MUL_C: begin
            prod_in  = mul_p;
            state_in = ST_DST_C;
         end
         ST_DST_C: begin
            state_in = ST_DWT_C;
         end
         ST_DWT_C: begin
            if (!div_busy) begin
               sc_in    = div_q[RC_W-1:0];
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            idx_in   = {1'b0, mul_p} + (P_W+1)'(sc_ff);
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_in.pixel_out = pix_sel;
            rsp_in.last      = row_end && col_end;
            rsp_valid_in     = 1'b1;
            if (col_end) begin
               col_in = '0;
               row_in = row_end ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_SRC_WIDTH, CSR_SRC_HEIGHT: begin
               if (csr_index == CSR_SRC_WIDTH) begin
                  src_w_in = csr_wdata;
               end else begin
                  src_h_in = csr_wdata;
               end
               load_addr_in = '0;
               load_col_in  = '0;
               load_row_in  = '0;
               full_in      = 1'b0;
            end
            CSR_DST_WIDTH, CSR_DST_HEIGHT: begin
               if (csr_index == CSR_DST_WIDTH) begin
                  dst_w_in = csr_wdata;
               end else begin
                  dst_h_in = csr_wdata;
               end
               row_in = '0;
               col_in = '0;
            end
            CSR_HAS_ALPHA: begin
               alpha_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_w_ff     <= CSR_W'(1);
         src_h_ff     <= CSR_W'(1);
         dst_w_ff     <= CSR_W'(1);
         dst_h_ff     <= CSR_W'(1);
         alpha_ff     <= 1'b1;
         load_addr_ff <= '0;
         load_col_ff  <= '0;
         load_row_ff  <= '0;
         full_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         dst_w_ff     <= dst_w_in;
         dst_h_ff     <= dst_h_in;
         alpha_ff     <= alpha_in;
         load_addr_ff <= load_addr_in;
         load_col_ff  <= load_col_in;
         load_row_ff  <= load_row_in;
         full_ff      <= full_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      prod_ff <= prod_in;
      sr_ff   <= sr_in;
      sc_ff   <= sc_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
